// File: rtl/kvt_pkg.sv
// Shared types and constants for the key/value table.
// Command codes, beat structs, stored pair layout and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 6;
	localparam int CNT_W    = 7;
	localparam int CAPACITY = 64;

	localparam logic [CNT_W-1:0] LIMIT_RST = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_UPDATE   = 3'd1,
		CMD_UPSERT   = 3'd2,
		CMD_ERASE    = 3'd3,
		CMD_LOOKUP   = 3'd4,
		CMD_READ_IDX = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key_in;
		logic [VAL_W-1:0] value_in;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] key_out;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} pair_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEARCH,
		ST_ACT,
		ST_SHIFT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// File: rtl/key_value_table_unit.sv
// Key/value table: insertion-ordered pairs in one synchronous memory, walked by a sequencer.
// Key commands scan the stored entries from slot 0 until a hit or the last entry; an erase then
// moves each entry above the slot down by one; read by index fetches only the addressed entry.
// Throughput: one command at a time, set by the single memory read port walking the entries.
// The next command is accepted once the previous result sits in the output register.
// Reset clears the pair count, the output valid and sets the limit to 64; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module key_value_table_unit #(
	parameter int CAPACITY = kvt_pkg::CAPACITY
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_wen,
	input  wire [kvt_pkg::CNT_W-1:0]  cfg_wdata,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire kvt_pkg::req_t        in_data,
	output logic                      out_valid,
	input  wire                       out_stall,
	output kvt_pkg::rsp_t             out_data
);

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = kvt_pkg::CNT_W;
	localparam int LW    = (CW > CNT_W) ? CW : CNT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	kvt_pkg::state_t state_q, state_d;
	kvt_pkg::req_t   req_q, req_d;
	kvt_pkg::pair_t  pair_mem_q [CAPACITY];
	kvt_pkg::pair_t  rdata_s1;
	kvt_pkg::pair_t  wr_data;
	kvt_pkg::rsp_t   out_q, out_d;

	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            scan_q, scan_d;
	logic [CNT_W-1:0]         limit_q;
	logic                     pend_s1;
	logic [AW-1:0]            idx_s1;
	logic                     found_q, found_d;
	logic [AW-1:0]            slot_q, slot_d;
	logic                     res_ok_q, res_ok_d;
	logic [kvt_pkg::KEY_W-1:0] res_key_q, res_key_d;
	logic [kvt_pkg::VAL_W-1:0] res_val_q, res_val_d;
	logic                     out_valid_q, out_valid_d;
	logic                     rd_en, we;
	logic [AW-1:0]            rd_addr, wr_addr;
	logic                     hit, scan_lt, can_ins, pos_ok;

	assign in_stall  = (state_q != kvt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign hit     = pend_s1 && (rdata_s1.key == req_q.key_in);
	assign scan_lt = (scan_q < count_q);
	assign can_ins = !found_q && (LW'(count_q) < LW'(limit_q)) && (count_q < CAP_C);
	assign pos_ok  = (LW'(req_q.position) < LW'(count_q));

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		count_d     = count_q;
		scan_d      = scan_q;
		found_d     = found_q;
		slot_d      = slot_q;
		res_ok_d    = res_ok_q;
		res_key_d   = res_key_q;
		res_val_d   = res_val_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && out_stall;
		rd_en       = 1'b0;
		rd_addr     = '0;
		we          = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		unique case (state_q)
			kvt_pkg::ST_IDLE: begin
				if (in_valid) begin
					req_d   = in_data;
					scan_d  = '0;
					found_d = 1'b0;
					unique case (in_data.cmd) inside
						kvt_pkg::CMD_INSERT, kvt_pkg::CMD_UPDATE, kvt_pkg::CMD_UPSERT,
						kvt_pkg::CMD_ERASE, kvt_pkg::CMD_LOOKUP: state_d = kvt_pkg::ST_SEARCH;
						kvt_pkg::CMD_READ_IDX:                   state_d = kvt_pkg::ST_FETCH;
						default:                                 state_d = kvt_pkg::ST_ACT;
					endcase
				end
			end
			kvt_pkg::ST_FETCH: begin
				if (pos_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(req_q.position);
				end
				state_d = kvt_pkg::ST_ACT;
			end
			kvt_pkg::ST_SEARCH: begin
				if (hit) begin
					found_d = 1'b1;
					slot_d  = idx_s1;
					state_d = kvt_pkg::ST_ACT;
				end else if (scan_lt) begin
					rd_en   = 1'b1;
					rd_addr = AW'(scan_q);
					scan_d  = scan_q + CW'(1);
				end else if (!pend_s1) begin
					state_d = kvt_pkg::ST_ACT;
				end
			end
			kvt_pkg::ST_ACT: begin
				res_ok_d  = 1'b0;
				res_key_d = '0;
				res_val_d = '0;
				state_d   = kvt_pkg::ST_RESP;
				case (req_q.cmd)
					kvt_pkg::CMD_INSERT: begin
						if (can_ins) begin
							we       = 1'b1;
							wr_addr  = AW'(count_q);
							wr_data  = '{key: req_q.key_in, value: req_q.value_in};
							count_d  = count_q + CW'(1);
							res_ok_d = 1'b1;
						end
					end
					kvt_pkg::CMD_UPDATE: begin
						if (found_q) begin
							we       = 1'b1;
							wr_addr  = slot_q;
							wr_data  = '{key: req_q.key_in, value: req_q.value_in};
							res_ok_d = 1'b1;
						end
					end
					kvt_pkg::CMD_UPSERT: begin
						if (found_q) begin
							we       = 1'b1;
							wr_addr  = slot_q;
							wr_data  = '{key: req_q.key_in, value: req_q.value_in};
							res_ok_d = 1'b1;
						end else if (can_ins) begin
							we       = 1'b1;
							wr_addr  = AW'(count_q);
							wr_data  = '{key: req_q.key_in, value: req_q.value_in};
							count_d  = count_q + CW'(1);
							res_ok_d = 1'b1;
						end
					end
					kvt_pkg::CMD_ERASE: begin
						if (found_q) begin
							scan_d  = CW'(slot_q) + CW'(1);
							state_d = kvt_pkg::ST_SHIFT;
						end
					end
					kvt_pkg::CMD_LOOKUP: begin
						if (found_q) begin
							res_ok_d  = 1'b1;
							res_val_d = rdata_s1.value;
						end
					end
					kvt_pkg::CMD_READ_IDX: begin
						if (pos_ok) begin
							res_ok_d  = 1'b1;
							res_key_d = rdata_s1.key;
							res_val_d = rdata_s1.value;
						end
					end
					default: begin
					end
				endcase
			end
			kvt_pkg::ST_SHIFT: begin
				if (pend_s1) begin
					we      = 1'b1;
					wr_addr = idx_s1 - AW'(1);
					wr_data = rdata_s1;
				end
				if (scan_lt) begin
					rd_en   = 1'b1;
					rd_addr = AW'(scan_q);
					scan_d  = scan_q + CW'(1);
				end else if (!pend_s1) begin
					count_d   = count_q - CW'(1);
					res_ok_d  = 1'b1;
					res_key_d = '0;
					res_val_d = '0;
					state_d   = kvt_pkg::ST_RESP;
				end
			end
			kvt_pkg::ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_d       = '{ok: res_ok_q, key_out: res_key_q, value_out: res_val_q,
						entry_count: CNT_W'(count_q)};
					out_valid_d = 1'b1;
					state_d     = kvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kvt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kvt_pkg::ST_IDLE;
			count_q     <= '0;
			limit_q     <= kvt_pkg::LIMIT_RST;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_s1     <= rd_en;
			out_valid_q <= out_valid_d;
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		scan_q    <= scan_d;
		found_q   <= found_d;
		slot_q    <= slot_d;
		res_ok_q  <= res_ok_d;
		res_key_q <= res_key_d;
		res_val_q <= res_val_d;
		out_q     <= out_d;
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pair_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= pair_mem_q[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("pair count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
			count_q == $past(count_q) - CW'(1)))
		else $error("pair count moved by more than one");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CW'(rd_addr) < count_q))
		else $error("read outside held entries");

	a_shift_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q == kvt_pkg::ST_SHIFT) |-> (CW'(wr_addr) + CW'(1) < count_q))
		else $error("erase shift write outside held entries");
`endif

endmodule

`default_nettype wire

// File: tb/sv/key_value_table_checker.sv
// Result checker for the key/value table: watches the command, result and limit beats,
// keeps its own copy of the table, predicts each result and compares it in order.
// Depends on kvt_pkg for the beat structs, command codes and sizes.
`timescale 1ns / 1ps

module key_value_table_checker (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wen,
	input  wire [kvt_pkg::CNT_W-1:0] cfg_wdata,
	input  wire                      in_valid,
	input  wire                      in_stall,
	input  kvt_pkg::req_t            in_data,
	input  wire                      out_valid,
	input  wire                      out_stall,
	input  kvt_pkg::rsp_t            out_data,
	output int                       errors,
	output int                       pending,
	output int                       results_seen
);
	import kvt_pkg::*;

	logic [KEY_W-1:0] stored_keys [CAPACITY];
	logic [VAL_W-1:0] stored_vals [CAPACITY];
	int               stored_count;
	int               count_limit;
	rsp_t             expected_rsp [$];
	int               err_count;
	int               seen_count;

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (err_count < 40)
			$display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
		err_count++;
	endtask

	function automatic rsp_t apply_command(input req_t c);
		rsp_t r;
		int   slot;
		int   room;
		r    = '0;
		slot = -1;
		room = (count_limit < CAPACITY) ? count_limit : CAPACITY;
		for (int i = 0; i < stored_count; i++)
			if (slot < 0 && stored_keys[i] == c.key_in)
				slot = i;
		if ((c.cmd == CMD_UPDATE || c.cmd == CMD_UPSERT) && slot >= 0) begin
			stored_vals[slot] = c.value_in;
			r.ok = 1'b1;
		end else if ((c.cmd == CMD_INSERT || c.cmd == CMD_UPSERT) && slot < 0 &&
				stored_count < room) begin
			stored_keys[stored_count] = c.key_in;
			stored_vals[stored_count] = c.value_in;
			stored_count++;
			r.ok = 1'b1;
		end else if (c.cmd == CMD_ERASE && slot >= 0) begin
			for (int i = slot; i < stored_count - 1; i++) begin
				stored_keys[i] = stored_keys[i + 1];
				stored_vals[i] = stored_vals[i + 1];
			end
			stored_count--;
			r.ok = 1'b1;
		end else if (c.cmd == CMD_LOOKUP && slot >= 0) begin
			r.value_out = stored_vals[slot];
			r.ok = 1'b1;
		end else if (c.cmd == CMD_READ_IDX && int'(c.position) < stored_count) begin
			r.key_out   = stored_keys[c.position];
			r.value_out = stored_vals[c.position];
			r.ok = 1'b1;
		end
		r.entry_count = CNT_W'(stored_count);
		return r;
	endfunction

	always @(posedge clk) begin : track
		rsp_t want;
		if (!arst_n) begin
			stored_count = 0;
			count_limit  = int'(LIMIT_RST);
			expected_rsp.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen_count++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("result beat with nothing expected", out_data.value_out, '0);
				end else begin
					want = expected_rsp.pop_front();
					if (out_data.ok !== want.ok)
						report_mismatch("ok", 32'(out_data.ok), 32'(want.ok));
					if (out_data.key_out !== want.key_out)
						report_mismatch("key_out", out_data.key_out, want.key_out);
					if (out_data.value_out !== want.value_out)
						report_mismatch("value_out", out_data.value_out, want.value_out);
					if (out_data.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(out_data.entry_count),
							32'(want.entry_count));
				end
			end
			if (cfg_wen)
				count_limit = int'(cfg_wdata);
			if (in_valid && !in_stall)
				expected_rsp.push_back(apply_command(in_data));
		end
		errors       <= err_count;
		pending      <= expected_rsp.size();
		results_seen <= seen_count;
	end

endmodule

// File: tb/sv/key_value_table_unit_tb.sv
// Testbench top for key_value_table_unit: drives commands and limit writes with random
// gaps and result back-pressure, and gives the verdict from the checker's counts.
// Depends on kvt_pkg, key_value_table_unit and key_value_table_checker.
`timescale 1ns / 1ps

module key_value_table_unit_tb;
	import kvt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int               LONG_HOLD   = 400;
	localparam int               PHASE_ITEMS = 200;
	localparam int               SETTLE      = 150;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [CNT_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	req_t             in_data;
	logic             out_valid;
	logic             out_stall;
	rsp_t             out_data;
	int               errors;
	int               pending;
	int               results_seen;
	bit               tx_steady;
	logic [KEY_W-1:0] key_pool [$];
	int               phase_limits [8] = '{127, 64, 0, 1, 5, 63, 33, 64};

	key_value_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	key_value_table_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, input logic [POS_W-1:0] p);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{cmd: c, key_in: k, value_in: v, position: p};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_limit(input int lim);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= CNT_W'(lim);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_phase(input int lim);
		int               pool_n;
		int               erase_w;
		int               split;
		int               w;
		logic [CMD_W-1:0] c;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		write_limit(lim);
		pool_n    = $urandom_range(6, 96);
		erase_w   = $urandom_range(4, 24);
		split     = 55 + erase_w + (45 - erase_w) / 2;
		tx_steady = ($urandom_range(0, 3) == 0);
		key_pool.delete();
		key_pool.push_back('0);
		key_pool.push_back('1);
		repeat (pool_n) key_pool.push_back($urandom);
		repeat (PHASE_ITEMS) begin
			w = $urandom_range(0, 99);
			if (w < 2)
				c = w[0] ? CMD_SPARE_A : CMD_SPARE_B;
			else if (w < 30)
				c = CMD_INSERT;
			else if (w < 40)
				c = CMD_UPDATE;
			else if (w < 55)
				c = CMD_UPSERT;
			else if (w < 55 + erase_w)
				c = CMD_ERASE;
			else if (w < split)
				c = CMD_LOOKUP;
			else
				c = CMD_READ_IDX;
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			issue(c, k, v, $urandom_range(0, 1) ? POS_W'($urandom_range(0, 63)) :
				POS_W'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_LOOKUP, '0, '0, '0);
		issue(CMD_READ_IDX, '0, '0, '0);
		issue(CMD_INSERT, '0, '1, '0);
		issue(CMD_INSERT, '1, '0, '1);
		issue(CMD_INSERT, '0, 32'h1234_5678, '0);
		issue(CMD_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, '0);
		issue(CMD_UPDATE, '0, 32'h5A5A_5A5A, '0);
		issue(CMD_UPDATE, 32'hDEAD_0001, 32'h0000_0001, '0);
		issue(CMD_UPSERT, '1, 32'h0F0F_0F0F, '0);
		issue(CMD_UPSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0);
		issue(CMD_LOOKUP, '1, '0, '0);
		issue(CMD_LOOKUP, 32'h8000_0000, '0, '0);
		issue(CMD_READ_IDX, '0, '0, 6'd3);
		issue(CMD_READ_IDX, '0, '0, 6'd4);
		issue(CMD_READ_IDX, '0, '0, '1);
		issue(CMD_ERASE, '0, '0, '0);
		issue(CMD_ERASE, '0, '0, '0);
		issue(CMD_READ_IDX, '0, '0, '0);
		issue(CMD_SPARE_A, '1, '1, '1);
		issue(CMD_SPARE_B, '1, '1, '1);
		// limit below the count: inserts fail until erases make room
		write_limit(2);
		issue(CMD_INSERT, 32'h7777_7777, '1, '0);
		issue(CMD_UPSERT, 32'h7777_7777, '1, '0);
		issue(CMD_UPDATE, '1, 32'h3C3C_3C3C, '0);
		issue(CMD_ERASE, 32'h1234_5678, '0, '0);
		issue(CMD_INSERT, 32'h7777_7777, '1, '0);
		issue(CMD_ERASE, '1, '0, '0);
		issue(CMD_INSERT, 32'h7777_7777, '1, '0);

		foreach (phase_limits[i])
			run_phase(phase_limits[i]);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : result_sink
		int hold;
		int hold_mark;
		int turn;
		bit rx_steady;
		hold_mark = 150;
		turn      = 0;
		rx_steady = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen >= hold_mark) begin
				hold      = LONG_HOLD;
				hold_mark = hold_mark + 600;
			end else begin
				hold = rx_steady ? 0 : idle_len();
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			turn++;
			if (turn % 50 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		#(25_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
rtl/kvt_pkg.sv
rtl/key_value_table_unit.sv
tb/sv/key_value_table_checker.sv
tb/sv/key_value_table_unit_tb.sv
